// File: hw/rtl/rcsg_pkg.sv
// Shared types and constants for the RGB contrast stretch / grayscale block.
`default_nettype none
package rcsg_pkg;

  localparam int PIX_W     = 8;
  localparam int LANES     = 3;
  localparam int DATA_W    = PIX_W * LANES;
  localparam int NUM_W     = 2 * PIX_W;
  localparam int SUM_W     = PIX_W + 2;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int USER_W    = 2;

  // Bit positions inside in_tuser
  localparam int TUSER_OP    = 0;
  localparam int TUSER_FIRST = 1;

  localparam logic OP_GATHER = 1'b0;
  localparam logic OP_APPLY  = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] GRAY_DIV = PIX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic gather;  // fold the accepted pixel into min/max
    logic load;    // set up the divider lanes from the accepted pixel
    logic step;    // one restoring division step on every lane
    logic emit;    // move the finished lanes into the output register
  } ctl_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/rgb_contrast_stretch_grayscale.sv
// Top level: RGB min/max contrast stretch and grayscale averaging on stream channels.
`default_nettype none
// A gather transfer (op = 0) folds the pixel into per-channel running min/max in the
// cycle it is accepted and produces no output; first = 1 restarts the statistics from
// that pixel. An apply transfer (op = 1) produces one output pixel: per channel
// floor((v-min)*255/(max-min)) clamped to 255, or 0 when max <= min or v <= min; in gray
// mode all three channels carry floor((r+g+b)/3). A gather leaves the input open. An apply
// transfer loads the divider lanes in its accepting cycle, then the input stays closed for
// eight steps of the three-lane restoring divider (one quotient bit per lane per cycle) and
// the handoff of the result to the output register, longer while the previous result still
// waits there; the next transfer is accepted while that result waits downstream.
// gray_mode is written through cfg_wr_en/cfg_wr_data; the user must write it only while no
// apply is in flight, as the block itself does not enforce this.
module rgb_contrast_stretch_grayscale (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,  // gray_mode
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [rcsg_pkg::DATA_W-1:0]  in_tdata,     // red_in, green_in, blue_in
  input  wire logic [rcsg_pkg::USER_W-1:0]  in_tuser,     // op, first
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [rcsg_pkg::DATA_W-1:0]  out_tdata     // red_out, green_out, blue_out
);
  import rcsg_pkg::*;

  ctl_cmd_t cmd;

  rcsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[TUSER_OP]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rcsg_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_first    (in_tuser[TUSER_FIRST]),
    .in_tdata    (in_tdata),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

// File: hw/rtl/rcsg_ctrl.sv
// Controller: sequences gather, divide and output handoff for one item at a time.
`default_nettype none
module rcsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_op,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output rcsg_pkg::ctl_cmd_t     cmd
);
  import rcsg_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid & in_tready;

  always_comb begin
    cmd.gather = acc & (in_op == OP_GATHER);
    cmd.load   = acc & (in_op == OP_APPLY);
    cmd.step   = (state_r == ST_DIV);
    cmd.emit   = (state_r == ST_DONE) & (~out_valid_r | out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (cmd.load) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (cmd.emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rcsg_datapath.sv
// Datapath: per-channel min/max statistics, three restoring divider lanes, output register.
`default_nettype none
module rcsg_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  rcsg_pkg::ctl_cmd_t                cmd,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  input  wire logic                         in_first,
  input  wire logic [rcsg_pkg::DATA_W-1:0]  in_tdata,
  output logic      [rcsg_pkg::DATA_W-1:0]  out_tdata
);
  import rcsg_pkg::*;

  logic             gray_mode_r;
  logic [PIX_W-1:0] lo_r   [LANES];
  logic [PIX_W-1:0] hi_r   [LANES];
  logic [PIX_W-1:0] lo_nxt [LANES];
  logic [PIX_W-1:0] hi_nxt [LANES];

  logic [PIX_W-1:0] rem_r  [LANES];
  logic [PIX_W-1:0] quo_r  [LANES];
  logic [PIX_W-1:0] dvs_r  [LANES];
  logic             zero_r [LANES];
  logic             ovf_r  [LANES];
  logic [DATA_W-1:0] out_data_r;

  logic [PIX_W-1:0] pix      [LANES];
  logic [NUM_W-1:0] num      [LANES];
  logic [PIX_W-1:0] dvs_ld   [LANES];
  logic             zero_ld  [LANES];
  logic [PIX_W-1:0] rem_step [LANES];
  logic             qbit     [LANES];
  logic [SUM_W-1:0] gray_sum;

  assign out_tdata = out_data_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pix[i] = in_tdata[i*PIX_W +: PIX_W];
    end
    gray_sum = SUM_W'(pix[0]) + SUM_W'(pix[1]) + SUM_W'(pix[2]);
  end

  // Statistics fold on gather
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lo_nxt[i] = lo_r[i];
      hi_nxt[i] = hi_r[i];
      if (cmd.gather) begin
        if (in_first) begin
          lo_nxt[i] = pix[i];
          hi_nxt[i] = pix[i];
        end else begin
          if (pix[i] < lo_r[i]) lo_nxt[i] = pix[i];
          if (pix[i] > hi_r[i]) hi_nxt[i] = pix[i];
        end
      end
    end
  end

  // Lane setup: numerator and divisor for stretch or gray average
  always_comb begin
    logic [PIX_W-1:0] diff;
    for (int i = 0; i < LANES; i++) begin
      diff = pix[i] - lo_r[i];
      if (gray_mode_r) begin
        num[i]     = NUM_W'(gray_sum);
        dvs_ld[i]  = GRAY_DIV;
        zero_ld[i] = 1'b0;
      end else begin
        // (v - low) * 255 as a shift and subtract
        num[i]     = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
        dvs_ld[i]  = hi_r[i] - lo_r[i];
        zero_ld[i] = (hi_r[i] <= lo_r[i]) | (pix[i] <= lo_r[i]);
      end
    end
  end

  // One restoring step per lane: shift in the next numerator bit, subtract if it fits
  always_comb begin
    logic [PIX_W:0] trial;
    for (int i = 0; i < LANES; i++) begin
      trial   = {rem_r[i], quo_r[i][PIX_W-1]};
      qbit[i] = (trial >= {1'b0, dvs_r[i]});
      if (qbit[i]) begin
        rem_step[i] = PIX_W'(trial - {1'b0, dvs_r[i]});
      end else begin
        rem_step[i] = trial[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_mode_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lo_r[i] <= PIX_MAX;
        hi_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        gray_mode_r <= cfg_wr_data;
      end
      for (int i = 0; i < LANES; i++) begin
        lo_r[i] <= lo_nxt[i];
        hi_r[i] <= hi_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (cmd.load) begin
        rem_r[i]  <= num[i][NUM_W-1:PIX_W];
        quo_r[i]  <= num[i][PIX_W-1:0];
        dvs_r[i]  <= dvs_ld[i];
        zero_r[i] <= zero_ld[i];
        // quotient would not fit in a pixel: clamp
        ovf_r[i]  <= (num[i][NUM_W-1:PIX_W] >= dvs_ld[i]);
      end else if (cmd.step) begin
        rem_r[i] <= rem_step[i];
        quo_r[i] <= {quo_r[i][PIX_W-2:0], qbit[i]};
      end
      if (cmd.emit) begin
        if (zero_r[i]) begin
          out_data_r[i*PIX_W +: PIX_W] <= '0;
        end else if (ovf_r[i]) begin
          out_data_r[i*PIX_W +: PIX_W] <= PIX_MAX;
        end else begin
          out_data_r[i*PIX_W +: PIX_W] <= quo_r[i];
        end
      end
    end
  end

endmodule
`default_nettype wire
